// ===== sv/rsp_pkg.sv =====
// Package for the reservation station pool: sizes, register map and the
// item, entry and dispatch types. Depends on nothing.
package rsp_pkg;

    localparam int RSP_STATIONS = 8;
    localparam int RSP_IDX_W    = (RSP_STATIONS > 1) ? $clog2(RSP_STATIONS) : 1;

    localparam int RSP_OP_W   = 6;
    localparam int RSP_TAG_W  = 6;
    localparam int RSP_VAL_W  = 32;
    localparam int RSP_ROB_W  = 6;
    localparam int RSP_BASE_W = 6;
    localparam int RSP_STN_W  = 7;

    localparam int RSP_DATA_W    = 32;
    localparam int RSP_PADDR_W   = 3;
    localparam int RSP_REG_IDX_W = 1;

    // Register indexes (byte address is four times the index).
    localparam logic [RSP_REG_IDX_W-1:0] RSP_REG_STATION_ID_BASE = 1'b0;

    typedef logic [RSP_IDX_W-1:0] t_idx;

    typedef struct packed {
        logic                 issue_valid;
        logic                 dispatch_req;
        logic [RSP_OP_W-1:0]  opcode;
        logic [RSP_TAG_W-1:0] src1_tag;
        logic [RSP_TAG_W-1:0] src2_tag;
        logic [RSP_VAL_W-1:0] src1_value;
        logic [RSP_VAL_W-1:0] src2_value;
        logic [RSP_VAL_W-1:0] imm_addr;
        logic [RSP_ROB_W-1:0] rob_tag;
        logic [RSP_VAL_W-1:0] inst_addr;
        logic [RSP_TAG_W-1:0] cdb_tag;
        logic [RSP_VAL_W-1:0] cdb_value;
    } t_in_item;

    typedef struct packed {
        logic                 out_valid;
        logic [RSP_OP_W-1:0]  out_opcode;
        logic [RSP_VAL_W-1:0] out_src1;
        logic [RSP_VAL_W-1:0] out_src2;
        logic [RSP_VAL_W-1:0] out_imm;
        logic [RSP_ROB_W-1:0] out_rob;
        logic [RSP_VAL_W-1:0] out_pc;
        logic [RSP_STN_W-1:0] out_station;
        logic                 pool_full;
    } t_out_item;

    typedef struct packed {
        logic [RSP_OP_W-1:0]  opcode;
        logic [RSP_TAG_W-1:0] tag1;
        logic [RSP_TAG_W-1:0] tag2;
        logic [RSP_VAL_W-1:0] val1;
        logic [RSP_VAL_W-1:0] val2;
        logic [RSP_VAL_W-1:0] imm;
        logic [RSP_ROB_W-1:0] rob;
        logic [RSP_VAL_W-1:0] pc;
    } t_entry;

    // Dispatch outcome of one tick, handed from the station bank to the top.
    typedef struct packed {
        logic   hit;
        t_idx   idx;
        t_entry entry;
        logic   pool_full;
    } t_disp;

endpackage

// ===== sv/rsp_in_if.sv =====
// Input channel of the reservation station pool: valid/ready plus one input word.
// Depends on rsp_pkg.
interface rsp_in_if;
    logic              valid;
    logic              ready;
    rsp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rsp_out_if.sv =====
// Result channel of the reservation station pool: valid/ready plus one result word.
// Depends on rsp_pkg.
interface rsp_out_if;
    logic               valid;
    logic               ready;
    rsp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rsp_station_bank.sv =====
// Station storage with the ready and free priority encoders, dispatch, issue
// and bus capture for one tick. Depends on rsp_pkg.
module rsp_station_bank (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rsp_pkg::t_in_item i_item,
    output rsp_pkg::t_disp    o_disp
);
    import rsp_pkg::*;

    logic   [RSP_STATIONS-1:0] r_busy;
    t_entry                    r_entry [RSP_STATIONS];

    logic   [RSP_STATIONS-1:0] n_busy;
    t_entry                    n_entry [RSP_STATIONS];

    logic [RSP_STATIONS-1:0] ready_vec;
    logic                    disp_hit;
    t_idx                    disp_idx;
    logic                    issue_hit;
    t_idx                    issue_idx;
    t_entry                  new_entry;
    logic                    cdb_live;

    // Lowest ready entry and lowest free entry, both from the current state.
    always_comb begin
        disp_hit  = 1'b0;
        disp_idx  = '0;
        issue_hit = 1'b0;
        issue_idx = '0;
        for (int i = RSP_STATIONS - 1; i >= 0; i--) begin
            ready_vec[i] = r_busy[i] && (r_entry[i].tag1 == '0) && (r_entry[i].tag2 == '0);
            if (ready_vec[i]) begin
                disp_hit = 1'b1;
                disp_idx = RSP_IDX_W'(i);
            end
            if (!r_busy[i]) begin
                issue_hit = 1'b1;
                issue_idx = RSP_IDX_W'(i);
            end
        end
        disp_hit  = disp_hit && i_item.dispatch_req;
        issue_hit = issue_hit && i_item.issue_valid;
    end

    assign new_entry = '{opcode: i_item.opcode,   tag1: i_item.src1_tag,
                         tag2:   i_item.src2_tag, val1: i_item.src1_value,
                         val2:   i_item.src2_value, imm: i_item.imm_addr,
                         rob:    i_item.rob_tag,  pc:  i_item.inst_addr};

    assign cdb_live = (i_item.cdb_tag != '0);

    always_comb begin
        for (int i = 0; i < RSP_STATIONS; i++) begin
            n_busy[i]  = r_busy[i];
            n_entry[i] = r_entry[i];
            if (disp_hit && (disp_idx == RSP_IDX_W'(i))) begin
                n_busy[i] = 1'b0;
            end
            if (issue_hit && (issue_idx == RSP_IDX_W'(i))) begin
                n_busy[i]  = 1'b1;
                n_entry[i] = new_entry;
            end
            if (n_busy[i] && cdb_live && (n_entry[i].tag1 == i_item.cdb_tag)) begin
                n_entry[i].val1 = i_item.cdb_value;
                n_entry[i].tag1 = '0;
            end
            if (n_busy[i] && cdb_live && (n_entry[i].tag2 == i_item.cdb_tag)) begin
                n_entry[i].val2 = i_item.cdb_value;
                n_entry[i].tag2 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_step) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int i = 0; i < RSP_STATIONS; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    assign o_disp.hit       = disp_hit;
    assign o_disp.idx       = disp_idx;
    assign o_disp.entry     = r_entry[disp_idx];
    assign o_disp.pool_full = &n_busy;

endmodule

// ===== sv/reservation_station_pool_core.sv =====
// Top level of the reservation station pool: input stage, result register and
// the APB register. Depends on rsp_pkg, rsp_in_if, rsp_out_if and rsp_station_bank.

// A pool of RSP_STATIONS Tomasulo reservation stations. Every word accepted on
// the input channel is one clock tick of the pool and produces exactly one
// result word. The tick dispatches the lowest busy station whose two source
// tags are zero (when dispatch_req is set), issues the new instruction into
// the lowest station that was free before the tick (when issue_valid is set;
// an issue into a full pool is dropped), and lets every busy station,
// including the one just issued, capture a nonzero cdb_tag broadcast. The
// result carries the dispatched station's fields and identifier, or all
// zeros when nothing was dispatched, plus the pool_full flag after the tick.
// The pool takes one word per cycle unless a result that is not taken stalls it.
// The edge that accepts a word loads the input register; the single-pass tick
// logic then runs into the result register when that register is empty or
// being emptied, and the result is offered from there. A result that is
// not taken holds the input register and then the input. The station
// identifier is station_id_base (register 0, byte address 0) plus the station
// index. Write station_id_base only while no word is in flight.
module reservation_station_pool_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rsp_in_if.sink                        i_issue,
    rsp_out_if.source                     o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsp_pkg::RSP_PADDR_W-1:0] paddr,
    input  logic [rsp_pkg::RSP_DATA_W-1:0]  pwdata,
    output logic [rsp_pkg::RSP_DATA_W-1:0]  prdata,
    output logic                          pready
);
    import rsp_pkg::*;

    logic                  r_s1_valid;
    t_in_item              r_s1_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    logic [RSP_BASE_W-1:0] r_station_base;

    logic                     s1_fire;
    logic                     in_fire;
    logic [RSP_REG_IDX_W-1:0] reg_idx;
    logic                     cfg_write;
    t_disp                    disp;
    t_out_item                n_out_item;

    // The tick runs when the input register holds a word and the result
    // register is empty or being emptied in this cycle.
    assign s1_fire = r_s1_valid && (!r_out_valid || o_result.ready);
    assign in_fire = i_issue.valid && i_issue.ready;

    assign i_issue.ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_issue.ready) begin
            r_s1_valid <= i_issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_issue.data;
        end
    end

    rsp_station_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_item  (r_s1_item),
        .o_disp  (disp)
    );

    // When nothing is dispatched every entry field, the identifier too, is zero.
    always_comb begin
        n_out_item           = '0;
        n_out_item.pool_full = disp.pool_full;
        if (disp.hit) begin
            n_out_item.out_valid   = 1'b1;
            n_out_item.out_opcode  = disp.entry.opcode;
            n_out_item.out_src1    = disp.entry.val1;
            n_out_item.out_src2    = disp.entry.val2;
            n_out_item.out_imm     = disp.entry.imm;
            n_out_item.out_rob     = disp.entry.rob;
            n_out_item.out_pc      = disp.entry.pc;
            n_out_item.out_station = RSP_STN_W'(r_station_base) + RSP_STN_W'(disp.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_item;

    // APB register port. Only the station identifier base exists.
    assign reg_idx   = paddr[RSP_PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_base <= '0;
        end else if (cfg_write && (reg_idx == RSP_REG_STATION_ID_BASE)) begin
            r_station_base <= pwdata[RSP_BASE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == RSP_REG_STATION_ID_BASE) begin
            prdata = RSP_DATA_W'(r_station_base);
        end
    end

endmodule

// ===== test/reservation_station_pool_core_test.sv =====
// Self-checking testbench for reservation_station_pool_core: directed and random words,
// a scoreboard class that predicts every dispatch, random stalls on both channels.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if and the pool RTL.
module reservation_station_pool_core_test;

    import rsp_pkg::*;

    // Scoreboard. It keeps its own copy of the station array and the
    // identifier base, advances the copy once per accepted input word, and
    // queues the result word that the tick must produce.
    class pool_scoreboard;
        bit                    busy [RSP_STATIONS];
        t_entry                slot [RSP_STATIONS];
        logic [RSP_BASE_W-1:0] id_base;
        t_out_item             dispatch_due [$];
        int                    errors;

        function new();
            foreach (busy[i]) begin
                busy[i] = 1'b0;
                slot[i] = '0;
            end
            id_base = '0;
            errors  = 0;
        endfunction

        function void set_base(logic [RSP_BASE_W-1:0] b);
            id_base = b;
        endfunction

        function int pending();
            return dispatch_due.size();
        endfunction

        // One clock tick of the pool. Dispatch and issue both look at the old
        // state; the broadcast is captured into the new state.
        function void run_tick(t_in_item w);
            bit        nxt_busy [RSP_STATIONS];
            t_entry    nxt [RSP_STATIONS];
            t_out_item res;
            res      = '0;
            nxt_busy = busy;
            nxt      = slot;
            if (w.dispatch_req) begin
                for (int i = 0; i < RSP_STATIONS; i++) begin
                    if (busy[i] && slot[i].tag1 == '0 && slot[i].tag2 == '0) begin
                        nxt_busy[i]     = 1'b0;
                        res.out_valid   = 1'b1;
                        res.out_opcode  = slot[i].opcode;
                        res.out_src1    = slot[i].val1;
                        res.out_src2    = slot[i].val2;
                        res.out_imm     = slot[i].imm;
                        res.out_rob     = slot[i].rob;
                        res.out_pc      = slot[i].pc;
                        res.out_station = RSP_STN_W'(id_base) + RSP_STN_W'(i);
                        break;
                    end
                end
            end
            if (w.issue_valid) begin
                for (int i = 0; i < RSP_STATIONS; i++) begin
                    if (!busy[i]) begin
                        nxt_busy[i]   = 1'b1;
                        nxt[i].opcode = w.opcode;
                        nxt[i].tag1   = w.src1_tag;
                        nxt[i].tag2   = w.src2_tag;
                        nxt[i].val1   = w.src1_value;
                        nxt[i].val2   = w.src2_value;
                        nxt[i].imm    = w.imm_addr;
                        nxt[i].rob    = w.rob_tag;
                        nxt[i].pc     = w.inst_addr;
                        break;
                    end
                end
            end
            if (w.cdb_tag != '0) begin
                for (int i = 0; i < RSP_STATIONS; i++) begin
                    if (nxt_busy[i] && nxt[i].tag1 == w.cdb_tag) begin
                        nxt[i].val1 = w.cdb_value;
                        nxt[i].tag1 = '0;
                    end
                    if (nxt_busy[i] && nxt[i].tag2 == w.cdb_tag) begin
                        nxt[i].val2 = w.cdb_value;
                        nxt[i].tag2 = '0;
                    end
                end
            end
            res.pool_full = 1'b1;
            foreach (nxt_busy[i]) begin
                if (!nxt_busy[i]) res.pool_full = 1'b0;
            end
            busy = nxt_busy;
            slot = nxt;
            dispatch_due.push_back(res);
        endfunction

        function void match(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_dispatch(t_out_item got);
            t_out_item want;
            if (dispatch_due.size() == 0) begin
                $display("%0t: result word %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = dispatch_due.pop_front();
            match("out_valid",   want.out_valid,   got.out_valid);
            match("out_opcode",  want.out_opcode,  got.out_opcode);
            match("out_src1",    want.out_src1,    got.out_src1);
            match("out_src2",    want.out_src2,    got.out_src2);
            match("out_imm",     want.out_imm,     got.out_imm);
            match("out_rob",     want.out_rob,     got.out_rob);
            match("out_pc",      want.out_pc,      got.out_pc);
            match("out_station", want.out_station, got.out_station);
            match("pool_full",   want.pool_full,   got.pool_full);
        endfunction

        // A tag that some busy station is still waiting for, or zero if none.
        function logic [RSP_TAG_W-1:0] waiting_tag();
            logic [RSP_TAG_W-1:0] open_tags [$];
            foreach (busy[i]) begin
                if (busy[i] && slot[i].tag1 != '0) open_tags.push_back(slot[i].tag1);
                if (busy[i] && slot[i].tag2 != '0) open_tags.push_back(slot[i].tag2);
            end
            if (open_tags.size() == 0) return '0;
            return open_tags[$urandom_range(open_tags.size() - 1)];
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [RSP_PADDR_W-1:0] paddr;
    logic [RSP_DATA_W-1:0] pwdata;
    logic [RSP_DATA_W-1:0] prdata;
    logic                  pready;

    rsp_in_if  issue_ch ();
    rsp_out_if result_ch ();

    pool_scoreboard sb = new();

    // Stall rates in percent, the random mix of the current burst, and the
    // remaining length of a forced hold-off on the result channel.
    int send_idle_pct;
    int recv_idle_pct;
    int issue_pct;
    int disp_pct;
    int hold_left;

    reservation_station_pool_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run, with plenty of margin over the slowest legal run.
    initial begin
        #2000000;
        $display("** reservation_station_pool_core: FAILED **");
        $finish;
    end

    // Both channels are observed at the rising edge, where the block samples
    // them too. The input word is noted before the result is checked, so the
    // ordering between the two never depends on the simulator.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (issue_ch.valid && issue_ch.ready) sb.run_tick(issue_ch.data);
            if (result_ch.valid && result_ch.ready) sb.check_dispatch(result_ch.data);
        end
    end

    // Result side. A pending hold-off takes precedence over the random stalls;
    // it is counted down here, one cycle per falling edge.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            result_ch.ready = 1'b0;
            hold_left--;
        end else begin
            result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [RSP_PADDR_W-1:0] reg_addr(logic [RSP_REG_IDX_W-1:0] idx);
        return RSP_PADDR_W'(idx * 4);
    endfunction

    // Offers one word, idling first at the current rate, and returns at the
    // falling edge after the word was taken. Valid stays high between words
    // unless the next call decides to idle.
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            issue_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        issue_ch.valid = 1'b1;
        issue_ch.data  = w;
        do @(posedge i_clk); while (!issue_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [RSP_REG_IDX_W-1:0] idx,
                             input logic [RSP_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = reg_addr(idx);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [RSP_REG_IDX_W-1:0] idx,
                            output logic [RSP_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = reg_addr(idx);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes the identifier base, reads it back, and hands it to the scoreboard.
    task automatic set_station_base(input logic [RSP_BASE_W-1:0] b);
        logic [RSP_DATA_W-1:0] readback;
        apb_write(RSP_REG_STATION_ID_BASE, RSP_DATA_W'(b));
        apb_read(RSP_REG_STATION_ID_BASE, readback);
        sb.match("station_id_base readback", RSP_DATA_W'(b), readback);
        sb.set_base(b);
    endtask

    // Stops offering words and waits until every result has come back. Each
    // word produces a result, so nothing is left in flight after that.
    task automatic wait_idle();
        issue_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic t_in_item make_word(
        input bit iv, input bit dr, input logic [RSP_OP_W-1:0] opc,
        input logic [RSP_TAG_W-1:0] t1, input logic [RSP_TAG_W-1:0] t2,
        input logic [RSP_VAL_W-1:0] v1, input logic [RSP_VAL_W-1:0] v2,
        input logic [RSP_VAL_W-1:0] imm, input logic [RSP_ROB_W-1:0] rob,
        input logic [RSP_VAL_W-1:0] pc, input logic [RSP_TAG_W-1:0] ct,
        input logic [RSP_VAL_W-1:0] cv);
        t_in_item w;
        w.issue_valid  = iv;
        w.dispatch_req = dr;
        w.opcode       = opc;
        w.src1_tag     = t1;
        w.src2_tag     = t2;
        w.src1_value   = v1;
        w.src2_value   = v2;
        w.imm_addr     = imm;
        w.rob_tag      = rob;
        w.inst_addr    = pc;
        w.cdb_tag      = ct;
        w.cdb_value    = cv;
        return w;
    endfunction

    // Operand tags lean toward zero and a small set of producers, so that
    // broadcasts hit often; the rest spans the whole tag range.
    function automatic logic [RSP_TAG_W-1:0] operand_tag();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return '0;
        if (pick < 85) return RSP_TAG_W'($urandom_range(1, 12));
        return RSP_TAG_W'($urandom);
    endfunction

    // Mostly well-formed traffic: the broadcast often carries a tag that a
    // busy station is waiting for. A small share is unconstrained noise.
    function automatic t_in_item random_word();
        t_in_item w;
        int       pick;
        w.issue_valid  = ($urandom_range(99) < issue_pct);
        w.dispatch_req = ($urandom_range(99) < disp_pct);
        w.opcode       = RSP_OP_W'($urandom);
        w.src1_tag     = operand_tag();
        w.src2_tag     = operand_tag();
        w.src1_value   = $urandom;
        w.src2_value   = $urandom;
        w.imm_addr     = $urandom;
        w.rob_tag      = RSP_ROB_W'($urandom);
        w.inst_addr    = $urandom;
        w.cdb_value    = $urandom;
        pick = $urandom_range(99);
        if (pick < 50) begin
            w.cdb_tag = sb.waiting_tag();
        end else if (pick < 75) begin
            w.cdb_tag = '0;
        end else begin
            w.cdb_tag = RSP_TAG_W'($urandom);
        end
        if ($urandom_range(99) < 8) begin
            w.issue_valid  = 1'($urandom);
            w.dispatch_req = 1'($urandom);
            w.src1_tag     = RSP_TAG_W'($urandom);
            w.src2_tag     = RSP_TAG_W'($urandom);
            w.cdb_tag      = RSP_TAG_W'($urandom);
        end
        return w;
    endfunction

    initial begin
        logic [RSP_TAG_W-1:0] first_tags [6];
        logic [RSP_TAG_W-1:0] second_tags [6];
        int                   phase;
        first_tags  = '{6'd5, 6'd0, 6'd5, 6'd9, 6'd5, 6'd9};
        second_tags = '{6'd0, 6'd9, 6'd9, 6'd5, 6'd5, 6'd9};

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        issue_ch.valid  = 1'b0;
        issue_ch.data   = '0;
        result_ch.ready = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        issue_pct       = 60;
        disp_pct        = 60;
        hold_left       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, identifier base at its reset value of zero.
        // An idle tick and a dispatch request on an empty pool give all zeros.
        send_word(make_word(0, 0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_word(make_word(0, 1, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        // All-ones instruction into station 0, then dispatch and issue in the
        // same tick: station 0 leaves while the new word lands in station 1.
        send_word(make_word(1, 0, '1, '0, '0, '1, '1, '1, '1, '1, '0, '0));
        send_word(make_word(1, 1, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        // Both operands wait on tag 63, which is broadcast in the issue tick
        // itself, so the station just issued captures it on both sides.
        send_word(make_word(1, 0, 6'h2A, 6'd63, 6'd63, 32'h1, 32'h2, 32'h3, 6'd17,
                            32'h1000, 6'd63, 32'hA5A5_A5A5));
        // Fill the rest with stations waiting on tags 5 and 9; the pool is full.
        for (int k = 0; k < 6; k++) begin
            send_word(make_word(1, 0, RSP_OP_W'(k), first_tags[k], second_tags[k],
                                $urandom, $urandom, $urandom, RSP_ROB_W'(k + 40),
                                $urandom, '0, '0));
        end
        // Issue into a full pool is dropped even though dispatch frees station 0.
        send_word(make_word(1, 1, 6'h15, '0, '0, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h7777_7777, 6'd21, 32'h2000, '0, '0));
        send_word(make_word(0, 0, '0, '0, '0, '0, '0, '0, '0, '0, 6'd5, 32'hDEAD_BEEF));
        // A zero cdb_tag must not touch operands whose tag is already zero.
        send_word(make_word(1, 0, 6'h03, '0, '0, 32'h1111_1111, 32'h2222_2222,
                            32'h3333_3333, 6'd33, 32'hFFFF_FFFF, '0, 32'h9999_9999));
        send_word(make_word(0, 1, '0, '0, '0, '0, '0, '0, '0, '0, 6'd9, 32'h0BAD_F00D));
        // Drain every station and dispatch once more on the empty pool.
        repeat (8) begin
            send_word(make_word(0, 1, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        end

        // Random part in three phases, each with its own base and stall mix.
        for (phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    set_station_base('1);
                    send_idle_pct = 23;
                    recv_idle_pct = 62;
                end
                1: begin
                    set_station_base(RSP_BASE_W'($urandom_range(1, 62)));
                    send_idle_pct = 62;
                    recv_idle_pct = 23;
                end
                default: begin
                    set_station_base('0);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // Long hold-off on the result side while words keep coming,
                    // so the pipeline backs up and the input stalls.
                    hold_left = 400;
                end
            endcase
            for (int n = 0; n < 510; n++) begin
                if (n % 40 == 0) begin
                    issue_pct = $urandom_range(20, 90);
                    disp_pct  = $urandom_range(30, 90);
                end
                send_word(random_word());
            end
        end

        issue_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** reservation_station_pool_core: PASSED **");
        end else begin
            $display("** reservation_station_pool_core: FAILED **");
        end
        $finish;
    end

endmodule
